// File: src/probe_interarrival_jitter_core_assert.svh
// Assertion macros for the probe inter-arrival jitter core.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef PROBE_INTERARRIVAL_JITTER_CORE_ASSERT_SVH
`define PROBE_INTERARRIVAL_JITTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PIJ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pij assertion failed");

// Next-cycle implication, disabled while in reset.
`define PIJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pij assertion failed");

`endif

// File: src/pij_pkg.sv
// Shared types, widths and arithmetic helpers for the jitter core.
// No dependencies.
`timescale 1ns / 1ps
package pij_pkg;

  localparam int TS_W    = 48;
  localparam int DLY_W   = 32;
  localparam int FRAC_W  = 4;
  localparam int JIT_W   = DLY_W + FRAC_W;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SKIP,    // lost record: state untouched
    KIND_SEED,    // first received record: delays only
    KIND_START,   // second received record: jitter takes |D|
    KIND_SMOOTH   // later records: first-order smoothing
  } item_kind_e;

  typedef struct packed {
    item_kind_e             kind;
    logic                   last;
    logic [JIT_W-1:0]       tgt_rt;
    logic [JIT_W-1:0]       tgt_fw;
    logic [JIT_W-1:0]       tgt_bw;
  } work_item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  // |cur - prev| scaled by 16, both taken as signed 32-bit delays
  function automatic logic [JIT_W-1:0] change_scaled(input logic [DLY_W-1:0] cur,
                                                     input logic [DLY_W-1:0] prev);
    logic [DLY_W:0]   a;
    logic [DLY_W:0]   b;
    logic [DLY_W:0]   d_ab;
    logic [DLY_W:0]   d_ba;
    logic [DLY_W-1:0] mag;
    a    = {cur[DLY_W-1], cur};
    b    = {prev[DLY_W-1], prev};
    d_ab = a - b;
    d_ba = b - a;
    mag  = d_ab[DLY_W] ? d_ba[DLY_W-1:0] : d_ab[DLY_W-1:0];
    return {mag, {FRAC_W{1'b0}}};
  endfunction

  // j + (t - j) / 16, quotient truncated toward zero
  function automatic logic [JIT_W-1:0] smooth(input logic [JIT_W-1:0] j,
                                              input logic [JIT_W-1:0] t);
    logic [JIT_W:0] up;
    logic [JIT_W:0] dn;
    up = {1'b0, t} - {1'b0, j};
    dn = {1'b0, j} - {1'b0, t};
    if (up[JIT_W]) begin
      return j - (dn[JIT_W-1:0] >> FRAC_W);
    end else begin
      return j + (up[JIT_W-1:0] >> FRAC_W);
    end
  endfunction

endpackage

// File: src/pij_front.sv
// Front end: registers the three delays of each record, classifies it
// against the run phase and previous delays, and pushes it to the queue. Uses pij_pkg.
`timescale 1ns / 1ps
module pij_front
  import pij_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             reply_received_i,
  input  logic [TS_W-1:0]  send_time_i,
  input  logic [TS_W-1:0]  far_arrival_time_i,
  input  logic [TS_W-1:0]  reply_arrival_time_i,
  input  logic             end_of_run_i,
  input  q_status_t        q_stat_i,
  output logic             push_o,
  output work_item_t       push_item_o
);

  logic             a_valid_q, a_valid_d;
  logic             a_recv_q;
  logic             a_last_q;
  logic [DLY_W-1:0] a_rt_q, a_fw_q, a_bw_q;
  logic [1:0]       phase_q, phase_d;
  logic [DLY_W-1:0] prev_rt_q, prev_rt_d;
  logic [DLY_W-1:0] prev_fw_q, prev_fw_d;
  logic [DLY_W-1:0] prev_bw_q, prev_bw_d;
  logic             take;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  assign push_o     = a_valid_q && !q_stat_i.full;
  assign in_stall_o = a_valid_q && q_stat_i.full;
  assign take       = in_valid_i && !in_stall_o;
  assign a_valid_d  = take || (a_valid_q && !push_o);

  // Delays wrap to 32 bits, so only the low timestamp bits matter
  always_ff @(posedge clk_i) begin
    if (take) begin
      a_recv_q <= reply_received_i;
      a_last_q <= end_of_run_i;
      a_rt_q   <= reply_arrival_time_i[DLY_W-1:0] - send_time_i[DLY_W-1:0];
      a_fw_q   <= far_arrival_time_i[DLY_W-1:0] - send_time_i[DLY_W-1:0];
      a_bw_q   <= reply_arrival_time_i[DLY_W-1:0] - far_arrival_time_i[DLY_W-1:0];
    end
  end

  always_comb begin
    push_item_o.last   = a_last_q;
    push_item_o.tgt_rt = change_scaled(a_rt_q, prev_rt_q);
    push_item_o.tgt_fw = change_scaled(a_fw_q, prev_fw_q);
    push_item_o.tgt_bw = change_scaled(a_bw_q, prev_bw_q);
    priority if (!a_recv_q) begin
      push_item_o.kind = KIND_SKIP;
    end else if (phase_q == PH_NONE) begin
      push_item_o.kind = KIND_SEED;
    end else if (phase_q == PH_ONE) begin
      push_item_o.kind = KIND_START;
    end else begin
      push_item_o.kind = KIND_SMOOTH;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    prev_rt_d = prev_rt_q;
    prev_fw_d = prev_fw_q;
    prev_bw_d = prev_bw_q;
    if (push_o) begin
      if (a_recv_q) begin
        phase_d   = (phase_q == PH_NONE) ? PH_ONE : PH_TWO;
        prev_rt_d = a_rt_q;
        prev_fw_d = a_fw_q;
        prev_bw_d = a_bw_q;
      end
      // end of run: back to the reset state after this record
      if (a_last_q) begin
        phase_d   = PH_NONE;
        prev_rt_d = '0;
        prev_fw_d = '0;
        prev_bw_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      phase_q   <= PH_NONE;
      prev_rt_q <= '0;
      prev_fw_q <= '0;
      prev_bw_q <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      phase_q   <= phase_d;
      prev_rt_q <= prev_rt_d;
      prev_fw_q <= prev_fw_d;
      prev_bw_q <= prev_bw_d;
    end
  end

endmodule

// File: src/pij_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Uses pij_pkg.
`timescale 1ns / 1ps
module pij_queue
  import pij_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  work_item_t  push_item_i,
  input  logic        pop_i,
  output work_item_t  pop_item_o,
  output q_status_t   status_o
);

  work_item_t         mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;

  assign pop_item_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/pij_back.sv
// Back end: applies each item to the jitter estimates and holds the result
// in an output register. Uses pij_pkg.
`timescale 1ns / 1ps
module pij_back
  import pij_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_stat_i,
  input  work_item_t       pop_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [JIT_W-1:0] jitter_round_trip_o,
  output logic [JIT_W-1:0] jitter_forward_o,
  output logic [JIT_W-1:0] jitter_backward_o,
  output logic             jitter_valid_o,
  output logic             run_done_o
);

  logic [JIT_W-1:0] est_rt_q, est_rt_d;
  logic [JIT_W-1:0] est_fw_q, est_fw_d;
  logic [JIT_W-1:0] est_bw_q, est_bw_d;
  logic             est_ok_q, est_ok_d;
  logic             out_valid_q, out_valid_d;
  logic [JIT_W-1:0] res_rt, res_fw, res_bw;
  logic             res_ok;
  logic [JIT_W-1:0] out_rt_q, out_fw_q, out_bw_q;
  logic             out_ok_q, out_done_q;

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_comb begin
    res_rt = est_rt_q;
    res_fw = est_fw_q;
    res_bw = est_bw_q;
    res_ok = est_ok_q;
    unique case (pop_item_i.kind)
      KIND_START: begin
        res_rt = pop_item_i.tgt_rt;
        res_fw = pop_item_i.tgt_fw;
        res_bw = pop_item_i.tgt_bw;
        res_ok = 1'b1;
      end
      KIND_SMOOTH: begin
        res_rt = smooth(est_rt_q, pop_item_i.tgt_rt);
        res_fw = smooth(est_fw_q, pop_item_i.tgt_fw);
        res_bw = smooth(est_bw_q, pop_item_i.tgt_bw);
        res_ok = 1'b1;
      end
      default: begin
        res_ok = est_ok_q;
      end
    endcase
  end

  always_comb begin
    est_rt_d = est_rt_q;
    est_fw_d = est_fw_q;
    est_bw_d = est_bw_q;
    est_ok_d = est_ok_q;
    if (pop_o) begin
      if (pop_item_i.last) begin
        est_rt_d = '0;
        est_fw_d = '0;
        est_bw_d = '0;
        est_ok_d = 1'b0;
      end else begin
        est_rt_d = res_rt;
        est_fw_d = res_fw;
        est_bw_d = res_bw;
        est_ok_d = res_ok;
      end
    end
  end

  // Hold the result while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rt_q   <= res_ok ? res_rt : '0;
      out_fw_q   <= res_ok ? res_fw : '0;
      out_bw_q   <= res_ok ? res_bw : '0;
      out_ok_q   <= res_ok;
      out_done_q <= pop_item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_rt_q    <= '0;
      est_fw_q    <= '0;
      est_bw_q    <= '0;
      est_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      est_rt_q    <= est_rt_d;
      est_fw_q    <= est_fw_d;
      est_bw_q    <= est_bw_d;
      est_ok_q    <= est_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign jitter_round_trip_o = out_rt_q;
  assign jitter_forward_o    = out_fw_q;
  assign jitter_backward_o   = out_bw_q;
  assign jitter_valid_o      = out_ok_q;
  assign run_done_o          = out_done_q;

endmodule

// File: src/probe_interarrival_jitter_core.sv
// Top level of the probe inter-arrival jitter core: front end, item queue, back end.
// Uses pij_pkg, pij_front, pij_queue, pij_back and the assertion macro header.
`timescale 1ns / 1ps
// One probe record is taken per cycle when nothing stalls, and each gives one
// result through the input register, a queue slot and the output register.
// The front end keeps the previous delays and run phase and forms |D|*16
// for the three delays; the back end folds that into the jitter estimates
// with one add-and-shift step per record, so a record can follow in every
// cycle. A four-entry queue lets either side stall without holding the
// other. Jitters are microseconds with 4 fraction bits and read zero until
// two received records have been seen in a run; end_of_run clears all
// state after its record's result is formed.
module probe_interarrival_jitter_core
  import pij_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             reply_received_i,
  input  logic [TS_W-1:0]  send_time_i,
  input  logic [TS_W-1:0]  far_arrival_time_i,
  input  logic [TS_W-1:0]  reply_arrival_time_i,
  input  logic             end_of_run_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [JIT_W-1:0] jitter_round_trip_o,
  output logic [JIT_W-1:0] jitter_forward_o,
  output logic [JIT_W-1:0] jitter_backward_o,
  output logic             jitter_valid_o,
  output logic             run_done_o
);

`include "probe_interarrival_jitter_core_assert.svh"

  q_status_t  q_stat;
  logic       push;
  logic       pop;
  work_item_t push_item;
  work_item_t pop_item;

  pij_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .reply_received_i    (reply_received_i),
    .send_time_i         (send_time_i),
    .far_arrival_time_i  (far_arrival_time_i),
    .reply_arrival_time_i(reply_arrival_time_i),
    .end_of_run_i        (end_of_run_i),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .push_item_o         (push_item)
  );

  pij_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_stat)
  );

  pij_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_stat_i            (q_stat),
    .pop_item_i          (pop_item),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .jitter_round_trip_o (jitter_round_trip_o),
    .jitter_forward_o    (jitter_forward_o),
    .jitter_backward_o   (jitter_backward_o),
    .jitter_valid_o      (jitter_valid_o),
    .run_done_o          (run_done_o)
  );

  `PIJ_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
  `PIJ_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
  `PIJ_ASSERT_NOW(a_count_bound, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
  `PIJ_ASSERT_NOW(a_zero_until_valid, out_valid_o && !jitter_valid_o,
                  jitter_round_trip_o == '0 && jitter_forward_o == '0 &&
                  jitter_backward_o == '0)
  `PIJ_ASSERT_NEXT(a_count_step, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1)

endmodule

// File: sim/probe_interarrival_jitter_core_check.sv
// Checker for the probe inter-arrival jitter core: watches both channels,
// predicts each result from the accepted probe records and compares in order.
// Depends on pij_pkg for the field widths.
`timescale 1ns / 1ps
module probe_interarrival_jitter_core_check
  import pij_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             reply_received_i,
  input  logic [TS_W-1:0]  send_time_i,
  input  logic [TS_W-1:0]  far_arrival_time_i,
  input  logic [TS_W-1:0]  reply_arrival_time_i,
  input  logic             end_of_run_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [JIT_W-1:0] jitter_round_trip_i,
  input  logic [JIT_W-1:0] jitter_forward_i,
  input  logic [JIT_W-1:0] jitter_backward_i,
  input  logic             jitter_valid_i,
  input  logic             run_done_i,
  output int               fail_count_o,
  output int               outstanding_o,
  output int               checked_o,
  output int               live_results_o,
  output int               runs_closed_o
);

  localparam longint GAIN_DIV = 16;

  typedef enum logic [1:0] {
    RUN_EMPTY,
    RUN_SEEDED,
    RUN_LIVE
  } run_phase_e;

  typedef struct packed {
    logic [JIT_W-1:0] rt;
    logic [JIT_W-1:0] fw;
    logic [JIT_W-1:0] bw;
    logic             ok;
    logic             closes;
  } jitter_answer_t;

  jitter_answer_t   answers_q[$];
  run_phase_e       phase;
  logic [DLY_W-1:0] last_rt, last_fw, last_bw;
  logic [JIT_W-1:0] est_rt, est_fw, est_bw;
  int               errs = 0;
  int               n_checked = 0;
  int               n_live = 0;
  int               n_closed = 0;

  initial begin
    fail_count_o   = 0;
    outstanding_o  = 0;
    checked_o      = 0;
    live_results_o = 0;
    runs_closed_o  = 0;
  end

  // Delay as the low 32 bits of a 48-bit timestamp difference
  function automatic logic [DLY_W-1:0] delay_of(input logic [TS_W-1:0] later,
                                                input logic [TS_W-1:0] earlier);
    logic [TS_W-1:0] span;
    span = later - earlier;
    return span[DLY_W-1:0];
  endfunction

  // Exact |now - was| of two signed delays, in jitter units
  function automatic logic [JIT_W-1:0] step_magnitude(input logic [DLY_W-1:0] now_d,
                                                      input logic [DLY_W-1:0] was_d);
    longint     d;
    logic [63:0] bits;
    d = longint'($signed(now_d)) - longint'($signed(was_d));
    if (d < 0) begin
      d = -d;
    end
    bits = d << FRAC_W;
    return bits[JIT_W-1:0];
  endfunction

  // Move the estimate a sixteenth of the way to the target, rounding toward zero
  function automatic logic [JIT_W-1:0] settle(input logic [JIT_W-1:0] est,
                                              input logic [JIT_W-1:0] aim);
    longint      gap;
    longint      nxt;
    logic [63:0] bits;
    gap  = longint'({{(64-JIT_W){1'b0}}, aim}) - longint'({{(64-JIT_W){1'b0}}, est});
    nxt  = longint'({{(64-JIT_W){1'b0}}, est}) + gap / GAIN_DIV;
    bits = nxt;
    return bits[JIT_W-1:0];
  endfunction

  task automatic clear_run();
    phase   = RUN_EMPTY;
    last_rt = '0;
    last_fw = '0;
    last_bw = '0;
    est_rt  = '0;
    est_fw  = '0;
    est_bw  = '0;
  endtask

  task automatic check_field(input string field, input logic [JIT_W-1:0] want,
                             input logic [JIT_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, seen);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin
    jitter_answer_t   want;
    logic [DLY_W-1:0] rt, fw, bw;
    if (!rst_ni) begin
      clear_run();
      answers_q.delete();
    end else begin
      // compare first: a result never belongs to the item accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          $error("result arrived with no probe record waiting for one");
          errs++;
        end else begin
          want = answers_q.pop_front();
          check_field("jitter_round_trip", want.rt, jitter_round_trip_i);
          check_field("jitter_forward", want.fw, jitter_forward_i);
          check_field("jitter_backward", want.bw, jitter_backward_i);
          check_field("jitter_valid", JIT_W'(want.ok), JIT_W'(jitter_valid_i));
          check_field("run_done", JIT_W'(want.closes), JIT_W'(run_done_i));
          n_checked++;
          if (want.ok) n_live++;
          if (want.closes) n_closed++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (reply_received_i) begin
          rt = delay_of(reply_arrival_time_i, send_time_i);
          fw = delay_of(far_arrival_time_i, send_time_i);
          bw = delay_of(reply_arrival_time_i, far_arrival_time_i);
          case (phase)
            RUN_SEEDED: begin
              est_rt = step_magnitude(rt, last_rt);
              est_fw = step_magnitude(fw, last_fw);
              est_bw = step_magnitude(bw, last_bw);
              phase  = RUN_LIVE;
            end
            RUN_LIVE: begin
              est_rt = settle(est_rt, step_magnitude(rt, last_rt));
              est_fw = settle(est_fw, step_magnitude(fw, last_fw));
              est_bw = settle(est_bw, step_magnitude(bw, last_bw));
            end
            default: begin
              phase = RUN_SEEDED;
            end
          endcase
          last_rt = rt;
          last_fw = fw;
          last_bw = bw;
        end
        want.ok     = (phase == RUN_LIVE);
        want.rt     = want.ok ? est_rt : '0;
        want.fw     = want.ok ? est_fw : '0;
        want.bw     = want.ok ? est_bw : '0;
        want.closes = end_of_run_i;
        answers_q.push_back(want);
        if (end_of_run_i) clear_run();
      end
    end
    fail_count_o   <= errs;
    outstanding_o  <= answers_q.size();
    checked_o      <= n_checked;
    live_results_o <= n_live;
    runs_closed_o  <= n_closed;
  end

endmodule

// File: sim/probe_interarrival_jitter_core_test.sv
// Testbench top for the probe inter-arrival jitter core: clock, reset, record
// stimulus, output stalls, watchdog and verdict.
// Depends on pij_pkg, the core and probe_interarrival_jitter_core_check.
`timescale 1ns / 1ps
module probe_interarrival_jitter_core_test;
  import pij_pkg::*;

  localparam int RECORD_TOTAL    = 1720;
  localparam int CALM_TAIL       = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  // longest correct quiet stretch is the hold-off above; allow several times that
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 12;

  localparam logic [TS_W-1:0] STAMP_MAX = '1;
  localparam logic [TS_W-1:0] DELAY_TOP = 48'h0000_7FFF_FFFF;
  localparam logic [TS_W-1:0] DELAY_NEG = 48'h0000_8000_0000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             reply_received_i = 1'b0;
  logic [TS_W-1:0]  send_time_i = '0;
  logic [TS_W-1:0]  far_arrival_time_i = '0;
  logic [TS_W-1:0]  reply_arrival_time_i = '0;
  logic             end_of_run_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [JIT_W-1:0] jitter_round_trip_o;
  logic [JIT_W-1:0] jitter_forward_o;
  logic [JIT_W-1:0] jitter_backward_o;
  logic             jitter_valid_o;
  logic             run_done_o;

  int fail_count, outstanding, checked, live_results, runs_closed;
  int sent_n = 0;
  int quiet_n = 0;
  bit calm = 1'b0;
  bit tx_lazy = 1'b1;
  bit held_long = 1'b0;
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  probe_interarrival_jitter_core u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .reply_received_i     (reply_received_i),
    .send_time_i          (send_time_i),
    .far_arrival_time_i   (far_arrival_time_i),
    .reply_arrival_time_i (reply_arrival_time_i),
    .end_of_run_i         (end_of_run_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .jitter_round_trip_o  (jitter_round_trip_o),
    .jitter_forward_o     (jitter_forward_o),
    .jitter_backward_o    (jitter_backward_o),
    .jitter_valid_o       (jitter_valid_o),
    .run_done_o           (run_done_o)
  );

  probe_interarrival_jitter_core_check u_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .reply_received_i     (reply_received_i),
    .send_time_i          (send_time_i),
    .far_arrival_time_i   (far_arrival_time_i),
    .reply_arrival_time_i (reply_arrival_time_i),
    .end_of_run_i         (end_of_run_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .jitter_round_trip_i  (jitter_round_trip_o),
    .jitter_forward_i     (jitter_forward_o),
    .jitter_backward_i    (jitter_backward_o),
    .jitter_valid_i       (jitter_valid_o),
    .run_done_i           (run_done_o),
    .fail_count_o         (fail_count),
    .outstanding_o        (outstanding),
    .checked_o            (checked),
    .live_results_o       (live_results),
    .runs_closed_o        (runs_closed)
  );

  function automatic logic [TS_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TS_W-1:0];
  endfunction

  // Offer one probe record, optionally after an idle burst, and hold it until taken
  task automatic offer(input logic got, input logic [TS_W-1:0] t_send,
                       input logic [TS_W-1:0] t_far, input logic [TS_W-1:0] t_reply,
                       input logic closes);
    calm = (sent_n >= RECORD_TOTAL - CALM_TAIL);
    if (!calm && tx_lazy && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    reply_received_i     <= got;
    send_time_i          <= t_send;
    far_arrival_time_i   <= t_far;
    reply_arrival_time_i <= t_reply;
    end_of_run_i         <= closes;
    do @(posedge clk_i); while (in_stall_o);
    sent_n++;
  endtask

  initial begin
    int unsigned      run_len, spread;
    logic [TS_W-1:0]  base, period, fwd_nom, bwd_nom, s, f;
    logic [31:0]      j_fw, j_bw;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lost record with nothing seen, then a lone record that also closes its run
    offer(1'b0, rand_stamp(), rand_stamp(), rand_stamp(), 1'b0);
    offer(1'b1, '0, '0, '0, 1'b1);
    // all-ones stamps, then a forward delay of minus one
    offer(1'b1, STAMP_MAX, STAMP_MAX, STAMP_MAX, 1'b0);
    offer(1'b1, '0, STAMP_MAX, STAMP_MAX, 1'b0);
    offer(1'b0, STAMP_MAX, '0, STAMP_MAX, 1'b0);
    offer(1'b1, '0, STAMP_MAX, STAMP_MAX, 1'b1);
    // largest delay change: top positive delay to most negative one
    offer(1'b1, '0, DELAY_TOP, DELAY_TOP, 1'b0);
    offer(1'b1, '0, DELAY_NEG, DELAY_NEG, 1'b0);
    repeat (4) offer(1'b1, '0, DELAY_NEG, DELAY_NEG, 1'b0);
    offer(1'b1, '0, '0, DELAY_TOP, 1'b0);
    offer(1'b1, 48'hFFFF_0000_0005, 48'h0000_0000_0003, 48'h1234_0000_0010, 1'b1);
    // run closed while only one record has been seen, then by a lost record alone
    offer(1'b1, 48'd100, 48'd160, 48'd230, 1'b0);
    offer(1'b0, 48'd200, 48'd260, 48'd330, 1'b1);
    offer(1'b0, rand_stamp(), rand_stamp(), rand_stamp(), 1'b1);
    // small upward steps so the estimate climbs with truncation
    offer(1'b1, 48'd1000, 48'd1050, 48'd1100, 1'b0);
    offer(1'b1, 48'd2000, 48'd2051, 48'd2103, 1'b0);
    offer(1'b1, 48'd3000, 48'd3049, 48'd3098, 1'b0);
    offer(1'b1, 48'd4000, 48'd4053, 48'd4105, 1'b1);

    while (sent_n < RECORD_TOTAL) begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      tx_lazy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) < 7) begin
        // well-formed run: regular sends, delays around a nominal value
        base    = rand_stamp();
        period  = TS_W'($urandom_range(1, 100000));
        fwd_nom = ($urandom_range(0, 1) != 0) ? {16'd0, $urandom}
                                              : TS_W'($urandom_range(0, 5000));
        bwd_nom = ($urandom_range(0, 1) != 0) ? {16'd0, $urandom}
                                              : TS_W'($urandom_range(0, 5000));
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = 15;
          2:       spread = 5000;
          default: spread = 32'h7FFF_FFFF;
        endcase
        for (int k = 0; k < run_len; k++) begin
          j_fw = $urandom_range(0, 2 * spread) - spread;
          j_bw = $urandom_range(0, 2 * spread) - spread;
          s    = base + period * TS_W'(k);
          f    = s + fwd_nom + {{16{j_fw[31]}}, j_fw};
          offer($urandom_range(0, 9) != 0, s, f, f + bwd_nom + {{16{j_bw[31]}}, j_bw},
                k == run_len - 1);
        end
      end else begin
        // noise: unrelated stamps, random loss and run ends
        repeat (run_len) begin
          offer($urandom_range(0, 1) != 0, rand_stamp(), rand_stamp(), rand_stamp(),
                $urandom_range(0, 7) == 0);
        end
      end
    end

    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d probe records; %0d results checked, %0d with valid jitter,",
             sent_n, checked, live_results);
    $display("%0d runs closed, output held off for %0d cycles once under load.",
             runs_closed, HOLD_OFF_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: random stall bursts, one long hold-off, none near the end
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    while (!stim_done) begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!held_long && sent_n > 400) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 1) != 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 19)) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: count cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_n <= 0;
    end else if (quiet_n + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

endmodule
